// ===== rtl/ccks_pkg.sv =====
// ----------------------------------------------------------------------------
// ccks_pkg
// Shared types, register codes and round functions of the keystream core.
// ----------------------------------------------------------------------------
package ccks_pkg;

   localparam int BLOCK_COUNT_DEF   = 8;
   localparam int DOUBLE_ROUNDS_DEF = 10;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_0_7    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_8_15   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_16_23  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_24_31  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NONCE_0_7  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NONCE_8_11 = 3'd5;

   localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

   typedef logic [15:0][31:0] words_type;

   typedef struct packed {
      logic [63:0] key_0_7;
      logic [63:0] key_8_15;
      logic [63:0] key_16_23;
      logic [63:0] key_24_31;
      logic [63:0] nonce_0_7;
      logic [31:0] nonce_8_11;
   } cfg_type;

   // head of the counter queue as seen by the back end
   typedef struct packed {
      logic        valid;
      logic [31:0] counter;
   } queue_head_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   function automatic words_type init_state(input cfg_type cfg, input logic [31:0] ctr);
      words_type s;
      s[0]  = SIGMA_0;
      s[1]  = SIGMA_1;
      s[2]  = SIGMA_2;
      s[3]  = SIGMA_3;
      s[4]  = cfg.key_0_7[31:0];
      s[5]  = cfg.key_0_7[63:32];
      s[6]  = cfg.key_8_15[31:0];
      s[7]  = cfg.key_8_15[63:32];
      s[8]  = cfg.key_16_23[31:0];
      s[9]  = cfg.key_16_23[63:32];
      s[10] = cfg.key_24_31[31:0];
      s[11] = cfg.key_24_31[63:32];
      s[12] = ctr;
      s[13] = cfg.nonce_0_7[31:0];
      s[14] = cfg.nonce_0_7[63:32];
      s[15] = cfg.nonce_8_11;
      return s;
   endfunction

   function automatic logic [3:0][31:0] quarter_round(input logic [3:0][31:0] v);
      logic [31:0] a, b, c, d;
      a = v[0];
      b = v[1];
      c = v[2];
      d = v[3];
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      return {d, c, b, a};
   endfunction

   // one column round (diag = 0) or one diagonal round (diag = 1)
   function automatic words_type chacha_round(input words_type x, input logic diag);
      words_type        y;
      logic [3:0][31:0] v;
      logic [3:0][31:0] r;
      int               s;
      int               ib, ic, id;
      y = x;
      s = diag ? 1 : 0;
      for (int i = 0; i < 4; i++) begin
         ib = 4 + ((i + s) & 3);
         ic = 8 + ((i + 2 * s) & 3);
         id = 12 + ((i + 3 * s) & 3);
         v = {x[id], x[ic], x[ib], x[i]};
         r = quarter_round(v);
         y[i]  = r[0];
         y[ib] = r[1];
         y[ic] = r[2];
         y[id] = r[3];
      end
      return y;
   endfunction

endpackage

// ===== rtl/ccks_front.sv =====
// ----------------------------------------------------------------------------
// ccks_front
// Configuration registers and the request queue of start counters.
// ----------------------------------------------------------------------------
module ccks_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [31:0]                          req_start_counter,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ccks_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ccks_pkg::CSR_DATA_W-1:0]      csr_data,
   output ccks_pkg::cfg_type                    cfg,
   output ccks_pkg::queue_head_type             head,
   input  logic                                 head_pop
);

   ccks_pkg::cfg_type cfg_ff, cfg_in;

   logic [31:0] q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push_w, pop_w;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ccks_pkg::REG_KEY_0_7:    cfg_in.key_0_7    = csr_data;
            ccks_pkg::REG_KEY_8_15:   cfg_in.key_8_15   = csr_data;
            ccks_pkg::REG_KEY_16_23:  cfg_in.key_16_23  = csr_data;
            ccks_pkg::REG_KEY_24_31:  cfg_in.key_24_31  = csr_data;
            ccks_pkg::REG_NONCE_0_7:  cfg_in.nonce_0_7  = csr_data;
            ccks_pkg::REG_NONCE_8_11: cfg_in.nonce_8_11 = csr_data[31:0];
            default: ;
         endcase
      end
   end

   assign req_full = (cnt_ff == 2'd2);
   assign push_w   = req_push && !req_full;
   assign pop_w    = head_pop && (cnt_ff != 2'd0);

   assign wr_ptr_in = push_w ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop_w ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push_w && !pop_w) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop_w && !push_w) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cfg_ff    <= cfg_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_w) begin
         q_ff[wr_ptr_ff] <= req_start_counter;
      end
   end

   assign cfg          = cfg_ff;
   assign head.valid   = (cnt_ff != 2'd0);
   assign head.counter = q_ff[rd_ptr_ff];

endmodule

// ===== rtl/ccks_back.sv =====
// ----------------------------------------------------------------------------
// ccks_back
// Round engine, feed-forward add and the word-pair output buffer.
// ----------------------------------------------------------------------------
module ccks_back #(
   parameter int BLOCK_COUNT   = ccks_pkg::BLOCK_COUNT_DEF,
   parameter int DOUBLE_ROUNDS = ccks_pkg::DOUBLE_ROUNDS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ccks_pkg::cfg_type          cfg,
   input  ccks_pkg::queue_head_type   head,
   output logic                       head_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [63:0]                rsp_keystream_pair,
   output logic [2:0]                 rsp_block_number,
   output logic [2:0]                 rsp_pair_number,
   output logic                       rsp_last_pair
);

   localparam int              ROUNDS   = 2 * DOUBLE_ROUNDS;
   localparam int              RND_W    = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);
   localparam logic [2:0]      BLK_LAST = 3'(BLOCK_COUNT - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [2:0]          blk_ff, blk_in;
   logic [31:0]         ctr_ff, ctr_in;
   ccks_pkg::words_type x_ff, x_in;

   ccks_pkg::words_type obuf_ff, obuf_in;
   logic                ovalid_ff, ovalid_in;
   logic [2:0]          opair_ff, opair_in;
   logic [2:0]          oblk_ff, oblk_in;

   ccks_pkg::words_type init_w;
   ccks_pkg::words_type final_w;
   logic                drain_last_w;
   logic                obuf_free_w;
   logic                load_w;

   assign drain_last_w = ovalid_ff && rsp_pop && (opair_ff == 3'd7);
   assign obuf_free_w  = !ovalid_ff || drain_last_w;
   assign load_w       = (state_ff == ST_DONE) && obuf_free_w;

   assign init_w = ccks_pkg::init_state(cfg, ctr_ff);

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         final_w[i] = x_ff[i] + init_w[i];
      end
   end

   // engine: one round per cycle, then a hand-off state per block that waits for a free output buffer
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      blk_in   = blk_ff;
      ctr_in   = ctr_ff;
      x_in     = x_ff;
      head_pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               head_pop = 1'b1;
               ctr_in   = head.counter;
               x_in     = ccks_pkg::init_state(cfg, head.counter);
               rnd_in   = '0;
               blk_in   = 3'd0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            x_in   = ccks_pkg::chacha_round(x_ff, rnd_ff[0]);
            rnd_in = rnd_ff + RND_W'(1);
            if (rnd_ff == RND_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (obuf_free_w) begin
               if (blk_ff == BLK_LAST) begin
                  blk_in   = 3'd0;
                  state_in = ST_IDLE;
               end else begin
                  blk_in   = blk_ff + 3'd1;
                  ctr_in   = ctr_ff + 32'd1;
                  x_in     = ccks_pkg::init_state(cfg, ctr_ff + 32'd1);
                  rnd_in   = '0;
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output buffer shifts down one pair per transaction
   always_comb begin
      obuf_in   = obuf_ff;
      ovalid_in = ovalid_ff;
      opair_in  = opair_ff;
      oblk_in   = oblk_ff;
      priority if (load_w) begin
         obuf_in   = final_w;
         ovalid_in = 1'b1;
         opair_in  = 3'd0;
         oblk_in   = blk_ff;
      end else if (ovalid_ff && rsp_pop) begin
         obuf_in   = {64'd0, obuf_ff[15:2]};
         opair_in  = opair_ff + 3'd1;
         if (opair_ff == 3'd7) begin
            ovalid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rnd_ff    <= '0;
         blk_ff    <= 3'd0;
         ovalid_ff <= 1'b0;
         opair_ff  <= 3'd0;
         oblk_ff   <= 3'd0;
      end else begin
         state_ff  <= state_in;
         rnd_ff    <= rnd_in;
         blk_ff    <= blk_in;
         ovalid_ff <= ovalid_in;
         opair_ff  <= opair_in;
         oblk_ff   <= oblk_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_ff  <= ctr_in;
      x_ff    <= x_in;
      obuf_ff <= obuf_in;
   end

   assign rsp_empty          = !ovalid_ff;
   assign rsp_keystream_pair = {obuf_ff[1], obuf_ff[0]};
   assign rsp_block_number   = oblk_ff;
   assign rsp_pair_number    = opair_ff;
   assign rsp_last_pair      = (oblk_ff == BLK_LAST) && (opair_ff == 3'd7);

   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (rnd_ff <= RND_LAST))
      else $error("round counter out of range");

   a_idle_blk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (blk_ff == 3'd0))
      else $error("block index not cleared while idle");

   a_oblk_range: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff |-> (oblk_ff <= BLK_LAST))
      else $error("output block number out of range");

   a_empty_pair: assert property (@(posedge clock) disable iff (reset)
      (!ovalid_ff && state_ff != ST_DONE) |=> (!ovalid_ff || opair_ff == 3'd0))
      else $error("output buffer filled without starting at pair zero");

endmodule

// ===== rtl/chacha20_keystream_blocks_core.sv =====
// ----------------------------------------------------------------------------
// chacha20_keystream_blocks_core
// ChaCha20 keystream generator, BLOCK_COUNT (eight by default) consecutive blocks per request.
// ----------------------------------------------------------------------------
// Usage: load the key and nonce through the csr_ write channel while the core
// is idle (csr_ready is always high). Push a start block counter with
// req_push when req_full is low; up to two requests wait in the front queue.
// Each request yields BLOCK_COUNT blocks (counters start, start+1, ... mod
// 2^32), each as eight word pairs on the rsp_ side, block-major, pair 0
// first; rsp_last_pair marks the final pair of the final block.
// The round engine takes a request off the queue while idle, then for each
// block runs alternating column and diagonal rounds, one round per cycle, and
// adds the input state back before handing the block off; it takes no new
// request until the last block of the current one has been handed off.
// The eight pairs of one block drain while the next block is computed.
// If the receiver holds pop low, the engine parks in its hand-off state until
// the output buffer is free; no pair is dropped. Reset clears the key, nonce,
// queue and engine state; the core comes out of reset idle and empty.
// ----------------------------------------------------------------------------
module chacha20_keystream_blocks_core #(
   parameter int BLOCK_COUNT   = ccks_pkg::BLOCK_COUNT_DEF,
   parameter int DOUBLE_ROUNDS = ccks_pkg::DOUBLE_ROUNDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [31:0]                       req_start_counter,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [63:0]                       rsp_keystream_pair,
   output logic [2:0]                        rsp_block_number,
   output logic [2:0]                        rsp_pair_number,
   output logic                              rsp_last_pair,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccks_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ccks_pkg::CSR_DATA_W-1:0]   csr_data
);

   ccks_pkg::cfg_type        cfg;
   ccks_pkg::queue_head_type head;
   logic                     head_pop;

   ccks_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_start_counter (req_start_counter),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cfg               (cfg),
      .head              (head),
      .head_pop          (head_pop)
   );

   ccks_back #(
      .BLOCK_COUNT   (BLOCK_COUNT),
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .head               (head),
      .head_pop           (head_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_keystream_pair (rsp_keystream_pair),
      .rsp_block_number   (rsp_block_number),
      .rsp_pair_number    (rsp_pair_number),
      .rsp_last_pair      (rsp_last_pair)
   );

endmodule

// ===== bench/tb_chacha20_keystream_blocks_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chacha20_keystream_blocks_core
// Self-checking bench for the eight-block ChaCha20 keystream core. Key and
// nonce are loaded through the csr_ channel while the core is idle, start
// counters are pushed in random bursts, and every word pair popped is checked
// in order against a block-function predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_chacha20_keystream_blocks_core;
   import ccks_pkg::*;

   localparam int BLOCKS      = BLOCK_COUNT_DEF;
   localparam int STALL_LIMIT = 5000;

   // indexes past the last register, writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [63:0] pair;
      logic [2:0]  block_num;
      logic [2:0]  pair_num;
      logic        last;
   } ks_pair_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [31:0]           req_start_counter = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [63:0]           rsp_keystream_pair;
   logic [2:0]            rsp_block_number;
   logic [2:0]            rsp_pair_number;
   logic                  rsp_last_pair;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   cfg_type     key_cfg;
   logic [31:0] start_queue[$];
   ks_pair_type pair_expect[$];
   int          items_queued;
   int          items_accepted;
   int          mismatches;
   int          burst_left;
   int          gap_left;
   int          idle_cycles;
   int          pop_phase;
   logic [15:0] pop_pattern = 16'hffff;

   chacha20_keystream_blocks_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_start_counter  (req_start_counter),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_keystream_pair (rsp_keystream_pair),
      .rsp_block_number   (rsp_block_number),
      .rsp_pair_number    (rsp_pair_number),
      .rsp_last_pair      (rsp_last_pair),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #4 clock = ~clock;

   function automatic words_type mix_quarter(input words_type x, input int a, input int b,
                                             input int c, input int d);
      logic [63:0] t;
      x[a] = x[a] + x[b];
      t = {2{x[d] ^ x[a]}} << 16;
      x[d] = t[63:32];
      x[c] = x[c] + x[d];
      t = {2{x[b] ^ x[c]}} << 12;
      x[b] = t[63:32];
      x[a] = x[a] + x[b];
      t = {2{x[d] ^ x[a]}} << 8;
      x[d] = t[63:32];
      x[c] = x[c] + x[d];
      t = {2{x[b] ^ x[c]}} << 7;
      x[b] = t[63:32];
      return x;
   endfunction

   function automatic words_type keystream_block(input cfg_type k, input logic [31:0] ctr);
      words_type seed;
      words_type x;
      seed = {k.nonce_8_11, k.nonce_0_7, ctr, k.key_24_31, k.key_16_23, k.key_8_15,
              k.key_0_7, SIGMA_3, SIGMA_2, SIGMA_1, SIGMA_0};
      x = seed;
      for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
         x = mix_quarter(x, 0, 4, 8, 12);
         x = mix_quarter(x, 1, 5, 9, 13);
         x = mix_quarter(x, 2, 6, 10, 14);
         x = mix_quarter(x, 3, 7, 11, 15);
         x = mix_quarter(x, 0, 5, 10, 15);
         x = mix_quarter(x, 1, 6, 11, 12);
         x = mix_quarter(x, 2, 7, 8, 13);
         x = mix_quarter(x, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++)
         x[i] = x[i] + seed[i];
      return x;
   endfunction

   // all pairs one start counter produces, block-major
   function automatic void queue_keystream(input logic [31:0] start);
      words_type   blk;
      ks_pair_type e;
      for (int b = 0; b < BLOCKS; b++) begin
         blk = keystream_block(key_cfg, start + 32'(b));
         for (int k = 0; k < 8; k++) begin
            e.pair      = {blk[2*k+1], blk[2*k]};
            e.block_num = 3'(b);
            e.pair_num  = 3'(k);
            e.last      = (b == BLOCKS - 1) && (k == 7);
            pair_expect.push_back(e);
         end
      end
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
   endtask

   // call right after a rising edge; caller lowers csr_valid after the last write
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_KEY_0_7:    key_cfg.key_0_7 = value;
         REG_KEY_8_15:   key_cfg.key_8_15 = value;
         REG_KEY_16_23:  key_cfg.key_16_23 = value;
         REG_KEY_24_31:  key_cfg.key_24_31 = value;
         REG_NONCE_0_7:  key_cfg.nonce_0_7 = value;
         REG_NONCE_8_11: key_cfg.nonce_8_11 = value[31:0];
         default: ;
      endcase
   endtask

   task automatic queue_start(input logic [31:0] ctr);
      start_queue.push_back(ctr);
      items_queued++;
   endtask

   // sender holds off until the core has delivered everything
   task automatic wait_idle();
      while (items_accepted != items_queued || pair_expect.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            queue_keystream(req_start_counter);
            items_accepted++;
         end
         if (!(req_push && req_full)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (start_queue.size() > 0) begin
               req_push          <= 1'b1;
               req_start_counter <= start_queue.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 10);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
               end
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // response monitor and pop pattern
   always @(posedge clock) begin
      ks_pair_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pair_expect.size() == 0) begin
               $display("%0t ns: unexpected pair, block %0d pair %0d data %h", $time,
                        rsp_block_number, rsp_pair_number, rsp_keystream_pair);
               mismatches++;
            end else begin
               e = pair_expect.pop_front();
               if (rsp_keystream_pair !== e.pair)
                  flag_mismatch("keystream_pair", e.pair, rsp_keystream_pair);
               if (rsp_block_number !== e.block_num)
                  flag_mismatch("block_number", 64'(e.block_num), 64'(rsp_block_number));
               if (rsp_pair_number !== e.pair_num)
                  flag_mismatch("pair_number", 64'(e.pair_num), 64'(rsp_pair_number));
               if (rsp_last_pair !== e.last)
                  flag_mismatch("last_pair", 64'(e.last), 64'(rsp_last_pair));
            end
         end
         pop_phase++;
         if (pop_phase % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: pop_pattern = 16'hffff;
               1: pop_pattern = 16'($urandom) | 16'h0001;
               2: pop_pattern = 16'($urandom & $urandom & $urandom) | 16'h0001;
               default: pop_pattern = 16'h0001 << $urandom_range(0, 15);
            endcase
         end
         rsp_pop <= pop_pattern[pop_phase % 16];
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb_chacha20_keystream_blocks_core: done, errors");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] value;
      key_cfg = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset key and nonce, counter wrap inside the request
      queue_start(32'h0000_0000);
      queue_start(32'hffff_ffff);
      queue_start(32'hffff_fffc);
      queue_start(32'h7fff_ffff);
      wait_idle();

      // published test key and nonce
      csr_write(REG_KEY_0_7, 64'h0706_0504_0302_0100);
      csr_write(REG_KEY_8_15, 64'h0f0e_0d0c_0b0a_0908);
      csr_write(REG_KEY_16_23, 64'h1716_1514_1312_1110);
      csr_write(REG_KEY_24_31, 64'h1f1e_1d1c_1b1a_1918);
      csr_write(REG_NONCE_0_7, 64'h4a00_0000_0900_0000);
      csr_write(REG_NONCE_8_11, 64'h0);
      csr_valid <= 1'b0;
      queue_start(32'h0000_0001);
      queue_start(32'h0000_0000);
      wait_idle();

      // all ones, then junk to the spare indexes
      csr_write(REG_KEY_0_7, '1);
      csr_write(REG_KEY_8_15, '1);
      csr_write(REG_KEY_16_23, '1);
      csr_write(REG_KEY_24_31, '1);
      csr_write(REG_NONCE_0_7, '1);
      csr_write(REG_NONCE_8_11, '1);
      csr_write(REG_SPARE_6, 64'h0123_4567_89ab_cdef);
      csr_write(REG_SPARE_7, '0);
      csr_valid <= 1'b0;
      queue_start(32'hffff_ffff);
      queue_start(32'h0000_0000);
      queue_start(32'haaaa_aaaa);
      queue_start(32'h5555_5555);
      wait_idle();

      // explicit zeros; upper half of the narrow nonce register is dropped
      csr_write(REG_KEY_0_7, '0);
      csr_write(REG_KEY_8_15, '0);
      csr_write(REG_KEY_16_23, '0);
      csr_write(REG_KEY_24_31, '0);
      csr_write(REG_NONCE_0_7, '0);
      csr_write(REG_NONCE_8_11, 64'hffff_ffff_0000_0000);
      csr_write(REG_SPARE_6, '1);
      csr_valid <= 1'b0;
      queue_start(32'hffff_fff9);
      queue_start(32'h1234_5678);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         for (int i = 0; i <= REG_SPARE_7; i++) begin
            if ($urandom_range(0, 3) != 0) begin
               case ($urandom_range(0, 7))
                  0: value = '0;
                  1: value = '1;
                  default: value = {$urandom, $urandom};
               endcase
               csr_write(CSR_IDX_W'(i), value);
            end
         end
         csr_valid <= 1'b0;
         for (int n = 0; n < 11; n++) begin
            if ($urandom_range(0, 3) == 0)
               queue_start($urandom_range(32'hffff_ffff, 32'hffff_fff0));
            else
               queue_start($urandom);
         end
         wait_idle();
      end

      // catch anything the core emits after the last expected pair
      repeat (4 * DOUBLE_ROUNDS_DEF) @(posedge clock);
      if (mismatches == 0 && pair_expect.size() == 0)
         $display("tb_chacha20_keystream_blocks_core: done, clean");
      else
         $display("tb_chacha20_keystream_blocks_core: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ccks_pkg.sv
rtl/ccks_front.sv
rtl/ccks_back.sv
rtl/chacha20_keystream_blocks_core.sv
bench/tb_chacha20_keystream_blocks_core.sv
